>>> hw/rtl/classd_pkg.sv
// ----------------------------------------------------------------------------
// classd_pkg
// types, register offsets and constants shared by the class d register front end
// ----------------------------------------------------------------------------
package classd_pkg;

	// item kinds
	typedef enum logic [1:0] {
		ACT_READ   = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_CLKUPD = 2'd3
	} action_t;

	// access widths
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;

	// configuration register indexes
	localparam logic CFG_GCLK = 1'b0;
	localparam logic CFG_PCLK = 1'b1;

	// register offsets
	localparam logic [7:0] OFF_CR     = 8'h00;
	localparam logic [7:0] OFF_MR     = 8'h04;
	localparam logic [7:0] OFF_INTPMR = 8'h08;
	localparam logic [7:0] OFF_INTSR  = 8'h0c;
	localparam logic [7:0] OFF_THR    = 8'h10;
	localparam logic [7:0] OFF_IER    = 8'h14;
	localparam logic [7:0] OFF_IDR    = 8'h18;
	localparam logic [7:0] OFF_IMR    = 8'h1c;
	localparam logic [7:0] OFF_ISR    = 8'h20;
	localparam logic [7:0] OFF_WPMR   = 8'he4;

	localparam logic [21:0] MODE_RESET   = 22'h010022;
	localparam logic [21:0] MODE_MASK    = 22'h310133;
	localparam logic [30:0] INTERP_RESET = 31'h00304e4e;
	localparam logic [30:0] INTERP_MASK  = 31'h7f7d7f7f;
	localparam logic [31:0] WP_KEY       = 32'h434c4400;
	localparam logic [31:0] WP_KEY_MASK  = 32'hffffff00;

	localparam logic [27:0] FREQ_48K = 28'd98304000;
	localparam logic [27:0] FREQ_44K = 28'd90316800;
	localparam logic [27:0] TOL_48K  = 28'd98;
	localparam logic [27:0] TOL_44K  = 28'd90;

	// one bus beat
	typedef struct packed {
		action_t     action;
		logic [7:0]  offset;
		logic [31:0] write_data;
		logic [1:0]  access_size;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		logic        dma_request;
		logic        converting;
	} result_t;

	// architectural state
	typedef struct packed {
		logic [21:0] mode;
		logic [30:0] interp;
		logic [31:0] holding;
		logic        irq_enable;
		logic        data_ready;
		logic        write_protect;
		logic        sample_held;
		logic        active;
		logic        timer_armed;
		logic [16:0] countdown;
	} state_t;

	localparam state_t STATE_RESET = '{
		mode:          MODE_RESET,
		interp:        INTERP_RESET,
		holding:       32'h0,
		irq_enable:    1'b0,
		data_ready:    1'b0,
		write_protect: 1'b0,
		sample_held:   1'b0,
		active:        1'b0,
		timer_armed:   1'b0,
		countdown:     17'd0
	};

	// sample period in ns per frame rate code
	function automatic logic [16:0] period_ns(input logic [2:0] frame);
		logic [16:0] p;
		case (frame)
			3'd0: p = 17'd125000;
			3'd1: p = 17'd62500;
			3'd2: p = 17'd31250;
			3'd3: p = 17'd20834;
			3'd4: p = 17'd10417;
			3'd5: p = 17'd45352;
			3'd6: p = 17'd22676;
			3'd7: p = 17'd11338;
			default: p = 17'd0;
		endcase
		return p;
	endfunction

endpackage

>>> hw/rtl/classd_cfg_err.sv
// ----------------------------------------------------------------------------
// classd_cfg_err
// checks the generated clock against the expected family rate and the family bit against the frame rate code
// ----------------------------------------------------------------------------
module classd_cfg_err (
	input  logic [27:0] gclk_hz,
	input  logic [30:0] interp,
	output logic        err
);

	logic [2:0]  frame;
	logic        fam44;
	logic [27:0] expect_hz;
	logic [27:0] tol;
	logic [27:0] diff;

	assign frame     = interp[22:20];
	assign fam44     = interp[16];
	assign expect_hz = fam44 ? classd_pkg::FREQ_44K : classd_pkg::FREQ_48K;
	assign tol       = fam44 ? classd_pkg::TOL_44K : classd_pkg::TOL_48K;
	assign diff      = (gclk_hz > expect_hz) ? (gclk_hz - expect_hz) : (expect_hz - gclk_hz);

	// family bit must agree with the frame rate code
	assign err = (gclk_hz != 28'd0) && ((fam44 != (frame >= 3'd5)) || (diff > tol));

endmodule

>>> hw/rtl/classd_step.sv
// ----------------------------------------------------------------------------
// classd_step
// next state and result of one bus beat
// ----------------------------------------------------------------------------
module classd_step (
	input  classd_pkg::item_t   item,
	input  classd_pkg::state_t  cur,
	input  logic [27:0]         gclk_hz,
	input  logic                pclk_on,
	output classd_pkg::state_t  nxt,
	output classd_pkg::result_t res
);

	logic [31:0] wmask;
	logic [31:0] val;
	logic        intp_wr;
	logic [30:0] interp_eval;
	logic        cerr;

	always_comb begin
		case (item.access_size)
			classd_pkg::SIZE_BYTE: wmask = 32'h0000_00ff;
			classd_pkg::SIZE_HALF: wmask = 32'h0000_ffff;
			default:               wmask = 32'hffff_ffff;
		endcase
	end

	assign val = item.write_data & wmask;

	// an accepted interpolation write is evaluated with its new value
	assign intp_wr = (item.action == classd_pkg::ACT_WRITE) && (item.offset == classd_pkg::OFF_INTPMR)
		&& !cur.write_protect;
	assign interp_eval = intp_wr ? (val[30:0] & classd_pkg::INTERP_MASK) : cur.interp;

	classd_cfg_err u_cfg_err (
		.gclk_hz (gclk_hz),
		.interp  (interp_eval),
		.err     (cerr)
	);

	always_comb begin
		classd_pkg::state_t n;
		logic [31:0] rd;
		logic        do_refresh;
		logic        act;
		n          = cur;
		rd         = 32'h0;
		do_refresh = 1'b0;
		act        = 1'b0;
		case (item.action)
			classd_pkg::ACT_READ: begin
				case (item.offset)
					classd_pkg::OFF_MR:     rd = {10'h0, cur.mode};
					classd_pkg::OFF_INTPMR: rd = {1'b0, cur.interp};
					classd_pkg::OFF_INTSR:  rd = {31'h0, cerr};
					classd_pkg::OFF_THR:    rd = cur.holding;
					classd_pkg::OFF_IMR:    rd = {31'h0, cur.irq_enable};
					classd_pkg::OFF_ISR: begin
						rd           = {31'h0, cur.data_ready};
						n.data_ready = 1'b0;
					end
					classd_pkg::OFF_WPMR:   rd = {31'h0, cur.write_protect};
					default:                rd = 32'h0;
				endcase
				rd = rd & wmask;
			end
			classd_pkg::ACT_WRITE: begin
				case (item.offset)
					classd_pkg::OFF_CR: begin
						if (val[0]) n = classd_pkg::STATE_RESET;
					end
					classd_pkg::OFF_MR: begin
						if (!cur.write_protect) begin
							n.mode     = val[21:0] & classd_pkg::MODE_MASK;
							do_refresh = 1'b1;
						end
					end
					classd_pkg::OFF_INTPMR: begin
						if (!cur.write_protect) begin
							n.interp      = interp_eval;
							n.timer_armed = 1'b0;
							n.countdown   = 17'd0;
							do_refresh    = 1'b1;
						end
					end
					classd_pkg::OFF_THR: begin
						n.holding     = (cur.holding & ~wmask) | val;
						n.sample_held = 1'b1;
					end
					classd_pkg::OFF_IER: begin
						if (val[0]) n.irq_enable = 1'b1;
					end
					classd_pkg::OFF_IDR: begin
						if (val[0]) n.irq_enable = 1'b0;
					end
					classd_pkg::OFF_WPMR: begin
						if ((val & classd_pkg::WP_KEY_MASK) == classd_pkg::WP_KEY)
							n.write_protect = val[0];
					end
					default: ;
				endcase
			end
			classd_pkg::ACT_TICK: begin
				if (cur.timer_armed) begin
					if (cur.countdown > 17'd1) begin
						n.countdown = cur.countdown - 17'd1;
					end else begin
						n.timer_armed = 1'b0;
						n.countdown   = 17'd0;
						if (cur.active) begin
							// period over: sample consumed, re-arm
							n.sample_held = 1'b0;
							n.data_ready  = 1'b1;
							n.timer_armed = 1'b1;
							n.countdown   = classd_pkg::period_ns(cur.interp[22:20]);
						end
					end
				end
			end
			default: begin
				n.timer_armed = 1'b0;
				n.countdown   = 17'd0;
				do_refresh    = 1'b1;
			end
		endcase

		if (do_refresh) begin
			act = (n.mode[0] || n.mode[4]) && (gclk_hz != 28'd0) && !cerr;
			if (act && !n.active && !n.sample_held) n.data_ready = 1'b1;
			n.active = act;
			if (!act) begin
				n.timer_armed = 1'b0;
				n.countdown   = 17'd0;
			end
			if (n.active && !n.timer_armed) begin
				n.timer_armed = 1'b1;
				n.countdown   = classd_pkg::period_ns(n.interp[22:20]);
			end
		end

		nxt             = n;
		res.read_data   = rd;
		res.irq         = n.data_ready && n.irq_enable && pclk_on;
		res.dma_request = n.active && !n.sample_held && pclk_on;
		res.converting  = n.active;
	end

endmodule

>>> hw/rtl/classd_amp_register_interface.sv
// ----------------------------------------------------------------------------
// classd_amp_register_interface
// register front end of a class d amplifier: bus access, sample timer, irq, dma
// ----------------------------------------------------------------------------
// a beat is taken into the input register, then the state update writes its
// result into the result register; one beat per cycle unless out_ready stalls
// the result register; the input register refills as a waiting result drains
// reset: arst_n clears all control state at once and loads the register reset
// values; gclk_hz resets to zero and pclk_on to one
// ----------------------------------------------------------------------------
module classd_amp_register_interface (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  offset,
	input  logic [31:0] write_data,
	input  logic [1:0]  access_size,
	// result beats
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        irq,
	output logic        dma_request,
	output logic        converting,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [27:0] cfg_data
);

	// input register
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [7:0]  offset_s1;
	logic [31:0] wdata_s1;
	logic [1:0]  size_s1;

	// architectural and configuration state
	classd_pkg::state_t state_q;
	classd_pkg::state_t state_nxt;
	logic [27:0]        gclk_hz_q;
	logic               pclk_on_q;

	// result register
	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic        irq_q;
	logic        dma_q;
	logic        conv_q;

	classd_pkg::item_t   item;
	classd_pkg::result_t res;
	logic                advance;
	logic                in_take;

	// the staged beat moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	assign cfg_ready = 1'b1;

	assign item.action      = classd_pkg::action_t'(action_s1);
	assign item.offset      = offset_s1;
	assign item.write_data  = wdata_s1;
	assign item.access_size = size_s1;

	classd_step u_step (
		.item    (item),
		.cur     (state_q),
		.gclk_hz (gclk_hz_q),
		.pclk_on (pclk_on_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= classd_pkg::STATE_RESET;
			gclk_hz_q   <= 28'd0;
			pclk_on_q   <= 1'b1;
		end else begin
			if (in_take) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;

			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// configuration beats
			if (cfg_valid) begin
				case (cfg_index)
					classd_pkg::CFG_GCLK: gclk_hz_q <= cfg_data;
					classd_pkg::CFG_PCLK: pclk_on_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			offset_s1 <= offset;
			wdata_s1  <= write_data;
			size_s1   <= access_size;
		end
		if (advance) begin
			read_data_q <= res.read_data;
			irq_q       <= res.irq;
			dma_q       <= res.dma_request;
			conv_q      <= res.converting;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign irq         = irq_q;
	assign dma_request = dma_q;
	assign converting  = conv_q;

endmodule
